/* hw/rtl/pem_pkg.sv */
// shared types and constants for the prewitt edge magnitude block
package pem_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

  // control tag that travels with every pixel through the pipeline
  typedef struct packed {
    logic valid;
    logic emit;
    logic row_end;
    logic frame_end;
  } tag_t;

endpackage

/* hw/rtl/pem_line_buffer.sv */
// raster counters, two line stores and first pipeline stage
module pem_line_buffer #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [pem_pkg::PIX_W-1:0]     pixel,
  input  logic [pem_pkg::IMG_W_W-1:0]   image_width,
  input  logic [pem_pkg::IMG_H_W-1:0]   image_height,
  output pem_pkg::tag_t                 tag1,
  output logic [pem_pkg::PIX_W-1:0]     top1,
  output logic [pem_pkg::PIX_W-1:0]     mid1,
  output logic [pem_pkg::PIX_W-1:0]     px1
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > pem_pkg::IMG_W_W) ? CW + 1 : pem_pkg::IMG_W_W;

  logic [pem_pkg::PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [pem_pkg::PIX_W-1:0] mem_b [MAX_WIDTH];

  logic [CW-1:0]                 col_count;
  logic [CW-1:0]                 col_count_next;
  logic [pem_pkg::IMG_H_W-1:0]   row_count;
  logic [pem_pkg::IMG_H_W-1:0]   row_count_next;
  logic [CW-1:0]                 addr1;

  logic                          acc;
  logic [WW-1:0]                 w_ext;
  logic [WW-1:0]                 w_eff;
  logic [pem_pkg::IMG_H_W-1:0]   h_eff;
  logic                          last_col;
  logic                          last_row;
  logic                          emit;

  assign acc = in_valid && adv;

  always_comb begin
    w_ext = WW'(image_width);
    if (w_ext < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (image_height < pem_pkg::IMG_H_W'(3)) begin
      h_eff = pem_pkg::IMG_H_W'(3);
    end else begin
      h_eff = image_height;
    end
    last_col = WW'(col_count) >= (w_eff - WW'(1));
    last_row = row_count >= (h_eff - pem_pkg::IMG_H_W'(1));
    emit     = (row_count >= pem_pkg::IMG_H_W'(2)) && (WW'(col_count) >= WW'(2));
    if (last_col) begin
      col_count_next = '0;
      row_count_next = last_row ? '0 : row_count + pem_pkg::IMG_H_W'(1);
    end else begin
      col_count_next = col_count + CW'(1);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      tag1      <= '0;
    end else begin
      if (acc) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      if (adv) begin
        tag1.valid     <= acc;
        tag1.emit      <= emit;
        tag1.row_end   <= last_col;
        tag1.frame_end <= last_col && last_row;
      end
    end
  end

  // previous row: read old value and write the new pixel at the same column
  always_ff @(posedge clk) begin
    if (acc) begin
      mid1         <= mem_a[col_count];
      mem_a[col_count] <= pixel;
    end
  end

  // row before that: takes the registered previous row value when stage one advances
  always_ff @(posedge clk) begin
    if (acc) begin
      top1 <= mem_b[col_count];
    end
    if (adv && tag1.valid) begin
      mem_b[addr1] <= mid1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1   <= pixel;
      addr1 <= col_count;
    end
  end

endmodule

/* hw/rtl/pem_gradient.sv */
// 3x3 window, prewitt gradients and their squares
module pem_gradient (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  pem_pkg::tag_t             tag1,
  input  logic [pem_pkg::PIX_W-1:0] top1,
  input  logic [pem_pkg::PIX_W-1:0] mid1,
  input  logic [pem_pkg::PIX_W-1:0] px1,
  output pem_pkg::tag_t             tag4,
  output logic [19:0]               sq_x,
  output logic [19:0]               sq_y
);

  logic [pem_pkg::PIX_W-1:0] win [9];
  pem_pkg::tag_t             tag2;
  pem_pkg::tag_t             tag3;
  logic [9:0]                abs_x;
  logic [9:0]                abs_y;
  logic [9:0]                sum_t;
  logic [9:0]                sum_b;
  logic [9:0]                sum_l;
  logic [9:0]                sum_r;
  logic [9:0]                dx;
  logic [9:0]                dy;

  // window shifts left on every pixel, new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (adv && tag1.valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= top1;
      win[5] <= mid1;
      win[8] <= px1;
    end
  end

  always_comb begin
    sum_t = {2'b00, win[0]} + {2'b00, win[1]} + {2'b00, win[2]};
    sum_b = {2'b00, win[6]} + {2'b00, win[7]} + {2'b00, win[8]};
    sum_l = {2'b00, win[0]} + {2'b00, win[3]} + {2'b00, win[6]};
    sum_r = {2'b00, win[2]} + {2'b00, win[5]} + {2'b00, win[8]};
    dx    = (sum_b >= sum_t) ? sum_b - sum_t : sum_t - sum_b;
    dy    = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
    end else if (adv) begin
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abs_x <= dx;
      abs_y <= dy;
      sq_x  <= abs_x * abs_x;
      sq_y  <= abs_y * abs_y;
    end
  end

endmodule

/* hw/rtl/pem_magnitude.sv */
// sum of squares, saturating integer square root and output register
module pem_magnitude (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  pem_pkg::tag_t             tag4,
  input  logic [19:0]               sq_x,
  input  logic [19:0]               sq_y,
  output logic                      out_valid,
  output logic [pem_pkg::PIX_W-1:0] magnitude,
  output logic                      row_end,
  output logic                      frame_end
);

  typedef struct packed {
    logic [10:0] rem;
    logic [7:0]  res;
  } root_t;

  function automatic root_t root_step(root_t cur, logic [1:0] pair);
    logic [10:0] rem_sh;
    logic [10:0] trial;
    root_t       nxt;
    rem_sh = {cur.rem[8:0], pair};
    trial  = {1'b0, cur.res, 2'b01};
    if (rem_sh >= trial) begin
      nxt.rem = rem_sh - trial;
      nxt.res = {cur.res[6:0], 1'b1};
    end else begin
      nxt.rem = rem_sh;
      nxt.res = {cur.res[6:0], 1'b0};
    end
    return nxt;
  endfunction

  pem_pkg::tag_t tag5;
  pem_pkg::tag_t tag6;
  logic [15:0]   sum5;
  logic          sat5;
  logic [7:0]    lo6;
  logic          sat6;
  root_t         part6;
  root_t         hi_next;
  root_t         lo_next;
  logic [20:0]   sum_full;

  assign sum_full = {1'b0, sq_x} + {1'b0, sq_y};

  always_comb begin
    hi_next = '0;
    for (int i = 7; i >= 4; i--) begin
      hi_next = root_step(hi_next, sum5[2*i +: 2]);
    end
    lo_next = part6;
    for (int i = 3; i >= 0; i--) begin
      lo_next = root_step(lo_next, lo6[2*i +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5      <= '0;
      tag6      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      tag5      <= tag4;
      tag6      <= tag5;
      out_valid <= tag6.valid && tag6.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum5      <= sum_full[15:0];
      sat5      <= |sum_full[20:16];
      part6     <= hi_next;
      lo6       <= sum5[7:0];
      sat6      <= sat5;
      magnitude <= sat6 ? 8'hFF : lo_next.res;
      row_end   <= tag6.row_end;
      frame_end <= tag6.frame_end;
    end
  end

endmodule

/* hw/rtl/prewitt_edge_magnitude.sv */
// top level of the prewitt edge magnitude pixel pipeline
//
//  channel | signals                                   | direction | moves
//  --------+-------------------------------------------+-----------+------------------------
//  input   | in_valid, in_ready, pixel                 | in        | one pixel per transaction
//  output  | out_valid, out_ready, magnitude,          | out       | one interior result per
//          | row_end, frame_end                        |           | transaction
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | one register write
//
// takes one pixel per clock unless stalled; seven register stages (line store read, window,
// abs, square, sum, two root stages), the first loaded by the accepting edge and the last
// being the output register
// reset clears counters, valid bits and window and sets width and height to 640 and 480;
// the line stores are not cleared; values that feed a result are written before read
// out_ready low with a result waiting freezes every stage and drops in_ready
// cfg_ready is always high; writes belong in idle time between frames
module prewitt_edge_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pem_pkg::PIX_W-1:0]      pixel,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pem_pkg::PIX_W-1:0]      magnitude,
  output logic                           row_end,
  output logic                           frame_end,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pem_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [pem_pkg::IMG_W_W-1:0] image_width;
  logic [pem_pkg::IMG_H_W-1:0] image_height;
  logic                        adv;

  pem_pkg::tag_t               tag1;
  pem_pkg::tag_t               tag4;
  logic [pem_pkg::PIX_W-1:0]   top1;
  logic [pem_pkg::PIX_W-1:0]   mid1;
  logic [pem_pkg::PIX_W-1:0]   px1;
  logic [19:0]                 sq_x;
  logic [19:0]                 sq_y;

  // whole pipeline moves unless a result sits unclaimed in the output register
  assign adv       = !(out_valid && !out_ready);
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pem_pkg::IMAGE_WIDTH_RESET;
      image_height <= pem_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pem_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[pem_pkg::IMG_W_W-1:0];
        end
        pem_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[pem_pkg::IMG_H_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // counters and line stores: stage one holds top, middle and new pixel
  pem_line_buffer #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buffer (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .pixel        (pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .tag1         (tag1),
    .top1         (top1),
    .mid1         (mid1),
    .px1          (px1)
  );

  // window, absolute gradients, squares
  pem_gradient u_gradient (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .tag1 (tag1),
    .top1 (top1),
    .mid1 (mid1),
    .px1  (px1),
    .tag4 (tag4),
    .sq_x (sq_x),
    .sq_y (sq_y)
  );

  // sum, saturation, root over two stages, output register
  pem_magnitude u_magnitude (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tag4      (tag4),
    .sq_x      (sq_x),
    .sq_y      (sq_y),
    .out_valid (out_valid),
    .magnitude (magnitude),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

endmodule

/* hw/rtl/pem_checker.sv */
// port level checks for the prewitt edge magnitude block and their bind
module pem_port_checks (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [pem_pkg::PIX_W-1:0]      pixel,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pem_pkg::PIX_W-1:0]      magnitude,
  input logic                           row_end,
  input logic                           frame_end,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [pem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [pem_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(row_end)
      && $stable(frame_end))
    else $error("stalled result changed");

  // the frame ends only on a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !frame_end || row_end)
    else $error("frame_end without row_end");

  // input is held back only by an unclaimed result
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back pressure");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind prewitt_edge_magnitude pem_port_checks u_pem_port_checks (.*);

/* tb/sv/pem_checker.sv */
// checker for the prewitt edge magnitude block: predicts each result and compares it
`timescale 1ns / 100ps

module pem_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [pem_pkg::PIX_W-1:0]      pixel,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [pem_pkg::PIX_W-1:0]      magnitude,
  input  logic                           row_end,
  input  logic                           frame_end,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pem_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import pem_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             row_end;
    logic             frame_end;
  } edge_result_t;

  edge_result_t       edge_q[$];
  logic [PIX_W-1:0]   line_prev [MAX_WIDTH];
  logic [PIX_W-1:0]   line_older [MAX_WIDTH];
  logic [PIX_W-1:0]   win [9];
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  int unsigned        col_q;
  int unsigned        row_q;
  int                 fails = 0;

  // bitwise integer square root, clamped to the pixel range
  function automatic logic [PIX_W-1:0] root_clamped(input int unsigned sum);
    int unsigned r;
    int unsigned t;
    int unsigned b;
    r = 0;
    for (b = 1 << 11; b != 0; b = b >> 1) begin
      t = r + b;
      if (t * t <= sum) r = t;
    end
    return (r > 255) ? 8'hFF : r[PIX_W-1:0];
  endfunction

  task automatic predict_magnitude(input logic [PIX_W-1:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int               gx;
    int               gy;
    int               r;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    logic             last_col;
    logic             last_row;
    edge_result_t     res;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 3) h = 3;
    c = (col_q >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_q;
    top_px = line_older[c];
    mid_px = line_prev[c];
    line_older[c] = mid_px;
    line_prev[c] = px;
    for (r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = px;
    last_col = (col_q >= w - 1);
    last_row = (row_q >= h - 1);
    if (row_q >= 2 && col_q >= 2) begin
      gx = int'(win[6]) + int'(win[7]) + int'(win[8])
         - int'(win[0]) - int'(win[1]) - int'(win[2]);
      gy = int'(win[2]) + int'(win[5]) + int'(win[8])
         - int'(win[0]) - int'(win[3]) - int'(win[6]);
      res.magnitude = root_clamped(gx * gx + gy * gy);
      res.row_end = last_col;
      res.frame_end = last_col && last_row;
      edge_q.push_back(res);
    end
    if (last_col) begin
      col_q = 0;
      row_q = last_row ? 0 : (row_q + 1) & 32'hFFFF;
    end else begin
      col_q = col_q + 1;
    end
  endtask

  task automatic check_result();
    edge_result_t want;
    if (edge_q.size() == 0) begin
      $error("unexpected result: magnitude %0d row_end %0b frame_end %0b",
             magnitude, row_end, frame_end);
      fails++;
    end else begin
      want = edge_q.pop_front();
      if (magnitude !== want.magnitude) begin
        $error("magnitude: expected %0d, actual %0d", want.magnitude, magnitude);
        fails++;
      end
      if (row_end !== want.row_end) begin
        $error("row_end: expected %0b, actual %0b", want.row_end, row_end);
        fails++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin : track
    int i;
    if (rst) begin
      edge_q.delete();
      width_reg = IMAGE_WIDTH_RESET;
      height_reg = IMAGE_HEIGHT_RESET;
      for (i = 0; i < MAX_WIDTH; i++) begin
        line_prev[i] = '0;
        line_older[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i] = '0;
      col_q = 0;
      row_q = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data[IMG_W_W-1:0];
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data;
      end
      if (in_valid && in_ready) predict_magnitude(pixel);
      if (out_valid && out_ready) begin
        check_result();
      end
    end
    fail_count <= fails;
    pending <= edge_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// testbench top: pixel and register stimulus, output back-pressure, watchdog and verdict
`timescale 1ns / 100ps

module tb_top;
  import pem_pkg::*;

  localparam int PIXELS_MAX      = 1024;
  localparam int RANDOM_ITEMS    = 800;
  // pipeline is seven deep; give pixels that make no result time to leave
  localparam int DRAIN_CYCLES    = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_IMAGE_HEIGHT + 1'b1;

  typedef enum int {PAT_UNIFORM, PAT_EXTREME, PAT_RAMP, PAT_DIM} pattern_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      magnitude;
  logic                  row_end;
  logic                  frame_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          steady = 1'b0;
  bit          squeeze_on = 1'b0;
  bit          squeeze_done;
  // where the next pixel lands in the frame, as the block sees it
  int unsigned width_eff;
  int unsigned height_eff;
  int unsigned col_pos;
  int unsigned row_pos;
  int          random_items;

  always #6 clk = ~clk;

  prewitt_edge_magnitude #(
    .MAX_WIDTH(PIXELS_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .magnitude(magnitude),
    .row_end(row_end),
    .frame_end(frame_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pem_checker #(
    .MAX_WIDTH(PIXELS_MAX)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .magnitude(magnitude),
    .row_end(row_end),
    .frame_end(frame_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel(input pattern_t pat, input int unsigned n);
    case (pat)
      PAT_UNIFORM: return PIX_W'($urandom_range(0, 255));
      // hard black and white edges push the root into saturation
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      // gentle slope with noise gives mid-range magnitudes
      PAT_RAMP:    return PIX_W'(n * 3 + $urandom_range(0, 7));
      default:     return PIX_W'($urandom_range(0, 15));
    endcase
  endfunction

  // one register write transaction; keeps the effective frame size in step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int unsigned v;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) begin
      v = data[IMG_W_W-1:0];
      width_eff = (v < 3) ? 3 : (v > PIXELS_MAX) ? PIXELS_MAX : v;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      v = data;
      height_eff = (v < 3) ? 3 : v;
    end
  endtask

  // one pixel transaction, then a random gap unless the phase runs steady
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    int gap;
    in_valid <= 1'b1;
    pixel    <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (col_pos >= width_eff - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= height_eff - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block is idle once every predicted result is out and the pipe has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // no transaction on any channel for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random ready pattern, plus one long hold-off while the sender
  // keeps pushing, so the pipe fills and in_ready has to drop
  initial begin : receiver
    int hold;
    out_ready = 1'b0;
    squeeze_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_on && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        out_ready <= 1'b1;
        repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12)) @(posedge clk);
        hold = pick_gap();
        if (hold > 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          len;
    int          phase;
    int unsigned wv;
    int unsigned hv;
    int unsigned new_w;
    pattern_t    pat;
    rst        = 1'b1;
    in_valid   = 1'b0;
    pixel      = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_IMAGE_WIDTH;
    cfg_data   = '0;
    width_eff  = IMAGE_WIDTH_RESET;
    height_eff = IMAGE_HEIGHT_RESET;
    col_pos    = 0;
    row_pos    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sizes below the minimum clamp to a 3x3 frame, and a write
    // to an index with no register behind it must change nothing
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_FIRST_UNUSED), (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    // dark rows over a white row: gradient far beyond the output range
    for (n = 0; n < 9; n++) send_pixel((n >= 6) ? 8'hFF : 8'h00);
    wait_idle();

    // directed: shrink the frame in the middle of a row; the row and the
    // frame have to end on the very next pixel
    write_reg(REG_IMAGE_WIDTH, 16'd5);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    for (n = 0; n < 13; n++) send_pixel(next_pixel(PAT_EXTREME, n));
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_pixel(next_pixel(PAT_UNIFORM, 0));
    wait_idle();

    // random phases, each one starting from an idle block
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      // sometimes close the open frame, so that the width may grow again;
      // a 3x3 frame ends within a few pixels
      if (!(col_pos == 0 && row_pos == 0) && $urandom_range(0, 1) == 1) begin
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        pat = pattern_t'($urandom_range(0, 3));
        n = 0;
        while (!(col_pos == 0 && row_pos == 0)) begin
          send_pixel(next_pixel(pat, n));
          n++;
        end
        random_items += n;
        wait_idle();
      end

      // first phases force the size extremes, the rest draw mostly small frames
      case (phase)
        0: begin wv = PIXELS_MAX; hv = 4; end
        1: begin wv = 16'hFFFF; hv = 16'hFFFF; end
        2: begin wv = 0; hv = 0; end
        3: begin wv = 4; hv = 6; end
        default: begin
          case ($urandom_range(0, 9))
            0:       wv = $urandom_range(0, 2);
            1:       wv = $urandom_range(25, 100);
            default: wv = $urandom_range(3, 24);
          endcase
          // stray bits above the width field are ignored by the block
          if ($urandom_range(0, 3) == 0) wv = wv | ($urandom_range(0, 31) << IMG_W_W);
          case ($urandom_range(0, 9))
            0:       hv = $urandom_range(0, 2);
            1:       hv = $urandom_range(11, 65535);
            default: hv = $urandom_range(3, 10);
          endcase
        end
      endcase
      new_w = wv % (1 << IMG_W_W);
      new_w = (new_w < 3) ? 3 : (new_w > PIXELS_MAX) ? PIXELS_MAX : new_w;
      // a wider row mid-frame would read line store entries never written
      if ((phase < 4 || $urandom_range(0, 9) < 7) &&
          ((col_pos == 0 && row_pos == 0) || new_w <= width_eff))
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wv));
      if (phase < 4 || $urandom_range(0, 9) < 7)
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hv));
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_FIRST_UNUSED), (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));

      // the widest frames only run part of a row; wide rows need three of
      // them before the first result shows up
      if (phase == 3) len = 400;
      else if (phase < 2) len = $urandom_range(20, 80);
      else if (width_eff > 64) len = 3 * width_eff + $urandom_range(1, 64);
      else len = $urandom_range(8, 120);

      // the hold-off phase runs the sender flat out
      squeeze_on = (phase == 3);
      steady = (phase == 3) || ($urandom_range(0, 3) == 0);
      pat = pattern_t'($urandom_range(0, 3));
      for (n = 0; n < len; n++) send_pixel(next_pixel(pat, n));
      random_items += len;
      wait_idle();
      steady = 1'b0;
      squeeze_on = 1'b0;
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/pem_pkg.sv
hw/rtl/pem_line_buffer.sv
hw/rtl/pem_gradient.sv
hw/rtl/pem_magnitude.sv
hw/rtl/prewitt_edge_magnitude.sv
hw/rtl/pem_checker.sv
tb/sv/pem_checker.sv
tb/sv/tb_top.sv
